### hw/rtl/lcp_pkg.sv
// Shared widths, types and codes for the closest-points block.
package lcp_pkg;

  localparam int CW     = 32;
  localparam int FB     = 16;
  localparam int DW     = CW + 1;
  localparam int PW     = 2 * DW;
  localparam int SW     = PW + 2;
  localparam int NW     = 2 * SW + 1;
  localparam int MNW    = NW + DW;
  localparam int MOW    = NW + SW;
  localparam int LB     = 32;
  localparam int LA     = (NW + LB - 1) / LB;
  localparam int LBN    = (SW + LB - 1) / LB;
  localparam int PFW    = (LA + LBN) * LB;
  localparam int QB     = CW + 2;
  localparam int ML     = 5;
  localparam int DL     = QB + 2;
  localparam int SL     = 2 * ML + 3 + DL;
  localparam int NLANE  = 8;
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);
  localparam int PTW    = 16;
  localparam int PRW    = 32;
  localparam int CIW    = 8;

  localparam logic [CIW-1:0] CFG_POINT_THR = CIW'(0);
  localparam logic [CIW-1:0] CFG_PAR_THR   = CIW'(1);

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;

  localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_B_DEGEN  = 2'd1,
    ST_A_DEGEN  = 2'd2,
    ST_PARALLEL = 2'd3
  } status_t;

  typedef struct packed {
    status_t      status;
    coord_t [2:0] a0;
    coord_t [2:0] b0;
    diff_t  [2:0] d21;
    diff_t  [2:0] d43;
    diff_t  [2:0] d13;
  } item_t;

  typedef struct packed {
    status_t      status;
    coord_t [2:0] a0;
    coord_t [2:0] b0;
    diff_t  [2:0] d21;
    diff_t  [2:0] d43;
  } side_t;

endpackage

### hw/rtl/lcp_front.sv
// Input stage: takes a query, forms the direction vectors and flags degenerate lines.
module lcp_front
  import lcp_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  coord_t [2:0]   a0_i,
  input  coord_t [2:0]   a1_i,
  input  coord_t [2:0]   b0_i,
  input  coord_t [2:0]   b1_i,
  input  logic [PTW-1:0] point_thr_i,
  input  logic           room_i,
  output item_t          item_o,
  output logic           item_valid_o
);

  function automatic logic tiny(input diff_t [2:0] d, input logic [PTW-1:0] t);
    logic          r;
    logic [DW-1:0] m;
    r = 1'b1;
    for (int k = 0; k < 3; k++) begin
      m = d[k][DW-1] ? DW'(-d[k]) : DW'(d[k]);
      if (m >= DW'(t)) r = 1'b0;
    end
    return r;
  endfunction

  item_t item_r, item_nxt;
  logic  v_r, v_nxt;
  logic  accept;

  assign busy   = !room_i;
  assign accept = start && !busy;

  always_comb begin
    item_nxt    = item_r;
    item_nxt.a0 = a0_i;
    item_nxt.b0 = b0_i;
    for (int k = 0; k < 3; k++) begin
      item_nxt.d21[k] = DW'(a1_i[k]) - DW'(a0_i[k]);
      item_nxt.d43[k] = DW'(b1_i[k]) - DW'(b0_i[k]);
      item_nxt.d13[k] = DW'(a0_i[k]) - DW'(b0_i[k]);
    end
    if (tiny(item_nxt.d43, point_thr_i)) begin
      item_nxt.status = ST_B_DEGEN;
    end else if (tiny(item_nxt.d21, point_thr_i)) begin
      item_nxt.status = ST_A_DEGEN;
    end else begin
      item_nxt.status = ST_FOUND;
    end
    v_nxt = accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
    if (accept) item_r <= item_nxt;
  end

  assign item_o       = item_r;
  assign item_valid_o = v_r;

endmodule

### hw/rtl/lcp_queue.sv
// Short FIFO between the input stage and the arithmetic pipeline.
module lcp_queue
  import lcp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_i,
  input  item_t item_i,
  output logic  room_o,
  output item_t head_o,
  output logic  valid_o
);

  item_t            mem_r [QDEPTH];
  logic [QAW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCW-1:0]   cnt_r, cnt_nxt;
  logic             pop;

  assign pop     = (cnt_r != '0);
  assign valid_o = pop;
  assign head_o  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push_i ? QAW'((32'(wp_r) + 1) % QDEPTH) : wp_r;
    rp_nxt  = pop ? QAW'((32'(rp_r) + 1) % QDEPTH) : rp_r;
    cnt_nxt = cnt_r + QCW'(push_i) - QCW'(pop);
  end

  assign room_o = (32'(cnt_nxt) < QDEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push_i) mem_r[wp_r] <= item_i;
  end

endmodule

### hw/rtl/lcp_mul.sv
// Pipelined wide signed multiplier built from 32x32 partial products.
module lcp_mul
  import lcp_pkg::*;
(
  input  logic                  clk,
  input  logic signed [NW-1:0]  a_i,
  input  logic signed [SW-1:0]  b_i,
  output logic signed [MOW-1:0] p_o
);

  logic [NW-1:0]      ma_r;
  logic [SW-1:0]      mb_r;
  logic [3:0]         ng_r;
  logic [2*LB-1:0]    pp_r  [LA][LBN];
  logic [PFW-1:0]     row_r [LA];
  logic [PFW-1:0]     row_nxt [LA];
  logic [PFW-1:0]     tot_r, tot_nxt;
  logic signed [MOW-1:0] p_r;
  logic [LA*LB-1:0]   mae;
  logic [LBN*LB-1:0]  mbe;

  assign mae = (LA*LB)'(ma_r);
  assign mbe = (LBN*LB)'(mb_r);

  always_comb begin
    for (int i = 0; i < LA; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < LBN; j++) begin
        row_nxt[i] = row_nxt[i] + (PFW'(pp_r[i][j]) << (j * LB));
      end
    end
    tot_nxt = '0;
    for (int i = 0; i < LA; i++) begin
      tot_nxt = tot_nxt + (row_r[i] << (i * LB));
    end
  end

  always_ff @(posedge clk) begin
    ma_r <= a_i[NW-1] ? NW'(-a_i) : NW'(a_i);
    mb_r <= b_i[SW-1] ? SW'(-b_i) : SW'(b_i);
    ng_r <= {ng_r[2:0], a_i[NW-1] ^ b_i[SW-1]};
    for (int i = 0; i < LA; i++) begin
      for (int j = 0; j < LBN; j++) begin
        pp_r[i][j] <= (2*LB)'(mae[i*LB +: LB]) * (2*LB)'(mbe[j*LB +: LB]);
      end
    end
    row_r <= row_nxt;
    tot_r <= tot_nxt;
    p_r   <= ng_r[3] ? -$signed(tot_r[MOW-1:0]) : $signed(tot_r[MOW-1:0]);
  end

  assign p_o = p_r;

endmodule

### hw/rtl/lcp_div.sv
// Pipelined restoring divider, eight lanes sharing one divisor, quotient limited to QB bits.
module lcp_div
  import lcp_pkg::*;
(
  input  logic                  clk,
  input  logic signed [MNW-1:0] num_i [NLANE],
  input  logic [NW-1:0]         den_i,
  output logic [QB-1:0]         q_o   [NLANE],
  output logic                  neg_o [NLANE],
  output logic                  ovf_o [NLANE]
);

  logic [MNW-1:0] mag_r  [NLANE];
  logic           nga_r  [NLANE];
  logic [NW-1:0]  dena_r;

  logic [NW-1:0]  den_r  [QB+1];
  logic [NW-1:0]  r_r    [QB+1][NLANE];
  logic [QB-1:0]  low_r  [QB+1][NLANE];
  logic [QB-1:0]  q_r    [QB+1][NLANE];
  logic           neg_r  [QB+1][NLANE];
  logic           ovf_r  [QB+1][NLANE];

  logic [NW:0]    r2     [QB][NLANE];
  logic           ge     [QB][NLANE];
  logic [NW:0]    rn     [QB][NLANE];

  always_comb begin
    for (int s = 0; s < QB; s++) begin
      for (int l = 0; l < NLANE; l++) begin
        r2[s][l] = {r_r[s][l], low_r[s][l][QB-1]};
        ge[s][l] = (r2[s][l] >= {1'b0, den_r[s]});
        rn[s][l] = ge[s][l] ? (r2[s][l] - {1'b0, den_r[s]}) : r2[s][l];
      end
    end
  end

  always_ff @(posedge clk) begin
    dena_r <= den_i;
    for (int l = 0; l < NLANE; l++) begin
      mag_r[l] <= num_i[l][MNW-1] ? MNW'(-num_i[l]) : MNW'(num_i[l]);
      nga_r[l] <= num_i[l][MNW-1];
    end
    den_r[0] <= dena_r;
    for (int l = 0; l < NLANE; l++) begin
      r_r[0][l]   <= NW'(mag_r[l][MNW-1:QB]);
      low_r[0][l] <= mag_r[l][QB-1:0];
      q_r[0][l]   <= '0;
      neg_r[0][l] <= nga_r[l];
      ovf_r[0][l] <= (NW'(mag_r[l][MNW-1:QB]) >= dena_r);
    end
    for (int s = 0; s < QB; s++) begin
      den_r[s+1] <= den_r[s];
      for (int l = 0; l < NLANE; l++) begin
        r_r[s+1][l]   <= rn[s][l][NW-1:0];
        low_r[s+1][l] <= {low_r[s][l][QB-2:0], 1'b0};
        q_r[s+1][l]   <= {q_r[s][l][QB-2:0], ge[s][l]};
        neg_r[s+1][l] <= neg_r[s][l];
        ovf_r[s+1][l] <= ovf_r[s][l];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      q_o[l]   = q_r[QB][l];
      neg_o[l] = neg_r[QB][l];
      ovf_o[l] = ovf_r[QB][l];
    end
  end

endmodule

### hw/rtl/lcp_back.sv
// Arithmetic pipeline: dot products, denominator and numerators, divisions, saturation.
module lcp_back
  import lcp_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  item_t          item_i,
  input  logic           item_valid_i,
  input  logic [PRW-1:0] par_thr_i,
  output logic           out_strobe_o,
  output status_t        out_status_o,
  output coord_t [2:0]   out_near_a_o,
  output coord_t [2:0]   out_near_b_o,
  output coord_t         out_param_a_o,
  output coord_t         out_param_b_o
);

  localparam int M1A [6] = '{4, 1, 0, 2, 0, 1};
  localparam int M1B [6] = '{3, 1, 1, 3, 4, 2};
  localparam int SP      = ML + 3;

  function automatic coord_t sat_c(input logic signed [QB+1:0] v);
    if (v > (QB+2)'(CMAX)) return CMAX;
    else if (v < (QB+2)'(CMIN)) return CMIN;
    else return v[CW-1:0];
  endfunction

  logic signed [PW-1:0]  prod_r [5][3];
  logic signed [SW-1:0]  dot_r  [5];
  side_t                 side_r [SL];
  side_t                 sp_side;
  logic [SL-1:0]         v_r;

  logic signed [MOW-1:0] m1 [6];
  logic signed [MOW-1:0] m2 [6];
  logic signed [NW-1:0]  den_c, den_r, na_r, nb_r;
  logic                  par_r;
  logic signed [NW-1:0]  dden_r [ML];
  logic signed [MNW-1:0] dpa_r  [ML];
  logic signed [MNW-1:0] dpb_r  [ML];

  logic signed [MNW-1:0] num    [NLANE];
  logic [QB-1:0]         dq     [NLANE];
  logic                  dneg   [NLANE];
  logic                  dovf   [NLANE];
  coord_t                res    [NLANE];

  logic                  strobe_r;
  status_t               status_r;
  coord_t [2:0]          near_a_r, near_b_r;
  coord_t                param_a_r, param_b_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      prod_r[0][k] <= PW'($signed(item_i.d13[k])) * PW'($signed(item_i.d43[k]));
      prod_r[1][k] <= PW'($signed(item_i.d43[k])) * PW'($signed(item_i.d21[k]));
      prod_r[2][k] <= PW'($signed(item_i.d13[k])) * PW'($signed(item_i.d21[k]));
      prod_r[3][k] <= PW'($signed(item_i.d43[k])) * PW'($signed(item_i.d43[k]));
      prod_r[4][k] <= PW'($signed(item_i.d21[k])) * PW'($signed(item_i.d21[k]));
    end
    for (int m = 0; m < 5; m++) begin
      dot_r[m] <= SW'(prod_r[m][0]) + SW'(prod_r[m][1]) + SW'(prod_r[m][2]);
    end
  end

  for (genvar i = 0; i < 6; i++) begin : g_m1
    lcp_mul u_mul (
      .clk (clk),
      .a_i (NW'(dot_r[M1A[i]])),
      .b_i (dot_r[M1B[i]]),
      .p_o (m1[i])
    );
  end

  assign den_c = NW'(m1[0] - m1[1]);

  always_ff @(posedge clk) begin
    den_r <= den_c;
    na_r  <= NW'(m1[2] - m1[3]);
    nb_r  <= NW'(m1[4] - m1[5]);
    par_r <= (den_c == '0) || ($unsigned(den_c) < NW'(par_thr_i));
    dden_r[0] <= den_r;
    dpa_r[0]  <= MNW'(na_r) <<< FB;
    dpb_r[0]  <= MNW'(nb_r) <<< FB;
    for (int i = 1; i < ML; i++) begin
      dden_r[i] <= dden_r[i-1];
      dpa_r[i]  <= dpa_r[i-1];
      dpb_r[i]  <= dpb_r[i-1];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_m2
    lcp_mul u_mul_a (
      .clk (clk),
      .a_i (na_r),
      .b_i (SW'($signed(side_r[ML+2].d21[i]))),
      .p_o (m2[i])
    );
    lcp_mul u_mul_b (
      .clk (clk),
      .a_i (nb_r),
      .b_i (SW'($signed(side_r[ML+2].d43[i]))),
      .p_o (m2[i+3])
    );
  end

  always_comb begin
    for (int l = 0; l < 6; l++) num[l] = MNW'(m2[l]);
    num[6] = dpa_r[ML-1];
    num[7] = dpb_r[ML-1];
  end

  lcp_div u_div (
    .clk   (clk),
    .num_i (num),
    .den_i ($unsigned(dden_r[ML-1])),
    .q_o   (dq),
    .neg_o (dneg),
    .ovf_o (dovf)
  );

  always_comb begin
    sp_side = side_r[SP-1];
    if (par_r && sp_side.status == ST_FOUND) sp_side.status = ST_PARALLEL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r      <= '0;
      strobe_r <= 1'b0;
    end else begin
      v_r      <= {v_r[SL-2:0], item_valid_i};
      strobe_r <= v_r[SL-1];
    end
    side_r[0].status <= item_i.status;
    side_r[0].a0     <= item_i.a0;
    side_r[0].b0     <= item_i.b0;
    side_r[0].d21    <= item_i.d21;
    side_r[0].d43    <= item_i.d43;
    for (int i = 1; i < SL; i++) begin
      side_r[i] <= (i == SP) ? sp_side : side_r[i-1];
    end
  end

  always_comb begin
    logic signed [QB+1:0] qx;
    logic signed [QB+1:0] base;
    for (int l = 0; l < NLANE; l++) begin
      qx = (QB+2)'({1'b0, dq[l]});
      if (dneg[l]) qx = -qx;
      if (l < 3) base = (QB+2)'(side_r[SL-1].a0[l]);
      else if (l < 6) base = (QB+2)'(side_r[SL-1].b0[l-3]);
      else base = '0;
      res[l] = dovf[l] ? (dneg[l] ? CMIN : CMAX) : sat_c(base + qx);
    end
  end

  always_ff @(posedge clk) begin
    status_r <= side_r[SL-1].status;
    if (side_r[SL-1].status == ST_FOUND) begin
      near_a_r  <= {res[2], res[1], res[0]};
      near_b_r  <= {res[5], res[4], res[3]};
      param_a_r <= res[6];
      param_b_r <= res[7];
    end else begin
      near_a_r  <= '0;
      near_b_r  <= '0;
      param_a_r <= '0;
      param_b_r <= '0;
    end
  end

  assign out_strobe_o  = strobe_r;
  assign out_status_o  = status_r;
  assign out_near_a_o  = near_a_r;
  assign out_near_b_o  = near_b_r;
  assign out_param_a_o = param_a_r;
  assign out_param_b_o = param_b_r;

  a_pop_enters : assert property (@(posedge clk) disable iff (!rst_n)
    item_valid_i |=> v_r[0])
    else $error("popped beat did not enter the pipeline");

  a_fixed_latency : assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] |-> ##SL out_strobe_o)
    else $error("result beat missing after pipeline latency");

  a_fail_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_o && out_status_o != ST_FOUND) |->
      (out_near_a_o == '0 && out_near_b_o == '0 &&
       out_param_a_o == '0 && out_param_b_o == '0))
    else $error("failure beat carries nonzero fields");

endmodule

### hw/rtl/line_line_closest_points.sv
// Top level: closest points between two 3D lines, config registers and channel wiring.
//
//  channel | ports                               | handshake
//  --------+-------------------------------------+--------------------------------
//  input   | start, busy, in_a0_x .. in_b1_z     | beat taken when start && !busy
//  result  | out_strobe, out_status .. out_param | one-cycle strobe, no backpressure
//  config  | cfg_valid, cfg_ready, cfg_index/data| write when cfg_valid && cfg_ready
//
//  One query per cycle sustained; busy stays low while queries stream in.
//  After its start beat, each result passes through the input stage, queue, products,
//  two wide multiplies of 5 stages, and a divider of QB+2 stages.
//  Synchronous active-low reset clears the valid pipeline and sets both thresholds to 1.
//  The result side cannot stall, so the queue never fills while results drain each cycle.
module line_line_closest_points
  import lcp_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  coord_t         in_a0_x,
  input  coord_t         in_a0_y,
  input  coord_t         in_a0_z,
  input  coord_t         in_a1_x,
  input  coord_t         in_a1_y,
  input  coord_t         in_a1_z,
  input  coord_t         in_b0_x,
  input  coord_t         in_b0_y,
  input  coord_t         in_b0_z,
  input  coord_t         in_b1_x,
  input  coord_t         in_b1_y,
  input  coord_t         in_b1_z,
  output logic           out_strobe,
  output logic [1:0]     out_status,
  output coord_t         out_near_a_x,
  output coord_t         out_near_a_y,
  output coord_t         out_near_a_z,
  output coord_t         out_near_b_x,
  output coord_t         out_near_b_y,
  output coord_t         out_near_b_z,
  output coord_t         out_param_a,
  output coord_t         out_param_b,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [CIW-1:0] cfg_index,
  input  logic [PRW-1:0] cfg_data
);

  logic [PTW-1:0] point_thr_r;
  logic [PRW-1:0] par_thr_r;

  item_t        f_item, q_head;
  logic         f_valid, q_room, q_valid;
  status_t      status;
  coord_t [2:0] near_a, near_b;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_thr_r <= PTW'(1);
      par_thr_r   <= PRW'(1);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_POINT_THR) begin
        point_thr_r <= cfg_data[PTW-1:0];
      end else if (cfg_index == CFG_PAR_THR) begin
        par_thr_r <= cfg_data;
      end
    end
  end

  lcp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .a0_i         ({in_a0_z, in_a0_y, in_a0_x}),
    .a1_i         ({in_a1_z, in_a1_y, in_a1_x}),
    .b0_i         ({in_b0_z, in_b0_y, in_b0_x}),
    .b1_i         ({in_b1_z, in_b1_y, in_b1_x}),
    .point_thr_i  (point_thr_r),
    .room_i       (q_room),
    .item_o       (f_item),
    .item_valid_o (f_valid)
  );

  lcp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (f_valid),
    .item_i  (f_item),
    .room_o  (q_room),
    .head_o  (q_head),
    .valid_o (q_valid)
  );

  lcp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_i        (q_head),
    .item_valid_i  (q_valid),
    .par_thr_i     (par_thr_r),
    .out_strobe_o  (out_strobe),
    .out_status_o  (status),
    .out_near_a_o  (near_a),
    .out_near_b_o  (near_b),
    .out_param_a_o (out_param_a),
    .out_param_b_o (out_param_b)
  );

  assign out_status   = status;
  assign out_near_a_x = near_a[0];
  assign out_near_a_y = near_a[1];
  assign out_near_a_z = near_a[2];
  assign out_near_b_x = near_b[0];
  assign out_near_b_y = near_b[1];
  assign out_near_b_z = near_b[2];

endmodule

### tb/sv/tb_line_line_closest_points.sv
// Testbench for the closest-points block: directed table, random queries, config sweeps.
`timescale 1ns / 100ps

module tb_line_line_closest_points;
  import lcp_pkg::*;

  typedef logic signed [383:0] wide_t;

  typedef struct packed {
    status_t status;
    coord_t  near_a_x;
    coord_t  near_a_y;
    coord_t  near_a_z;
    coord_t  near_b_x;
    coord_t  near_b_y;
    coord_t  near_b_z;
    coord_t  param_a;
    coord_t  param_b;
  } answer_t;

  typedef struct {
    coord_t  pt[12];
    bit      known;
    answer_t ans;
  } query_row_t;

  localparam logic [CIW-1:0] CFG_UNUSED = CIW'(5);
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 60;
  localparam coord_t ONE = 32'sd65536;

  logic           clk;
  logic           rst_n;
  logic           start;
  logic           busy;
  coord_t         pt[12];
  logic           out_strobe;
  logic [1:0]     out_status;
  coord_t         out_near_a_x, out_near_a_y, out_near_a_z;
  coord_t         out_near_b_x, out_near_b_y, out_near_b_z;
  coord_t         out_param_a, out_param_b;
  logic           cfg_valid;
  logic           cfg_ready;
  logic [CIW-1:0] cfg_index;
  logic [PRW-1:0] cfg_data;

  logic [PTW-1:0] point_thr;
  logic [PRW-1:0] par_thr;
  answer_t        pending_answers[$];
  query_row_t     rows[$];
  int             errors;
  int             queries_sent;
  int             answers_seen;
  int             idle_cycles;
  int             status_hits[4];

  line_line_closest_points dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_a0_x(pt[0]), .in_a0_y(pt[1]), .in_a0_z(pt[2]),
    .in_a1_x(pt[3]), .in_a1_y(pt[4]), .in_a1_z(pt[5]),
    .in_b0_x(pt[6]), .in_b0_y(pt[7]), .in_b0_z(pt[8]),
    .in_b1_x(pt[9]), .in_b1_y(pt[10]), .in_b1_z(pt[11]),
    .out_strobe(out_strobe), .out_status(out_status),
    .out_near_a_x(out_near_a_x), .out_near_a_y(out_near_a_y), .out_near_a_z(out_near_a_z),
    .out_near_b_x(out_near_b_x), .out_near_b_y(out_near_b_y), .out_near_b_z(out_near_b_z),
    .out_param_a(out_param_a), .out_param_b(out_param_b),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void add_row(input query_row_t r);
    rows.insert(rows.size(), r);
  endfunction

  function automatic void expect_answer(input answer_t a);
    pending_answers.insert(pending_answers.size(), a);
  endfunction

  function automatic coord_t saturate(wide_t x);
    wide_t hi;
    wide_t lo;
    hi = CMAX;
    lo = CMIN;
    if (x > hi) return CMAX;
    if (x < lo) return CMIN;
    return x[CW-1:0];
  endfunction

  function automatic answer_t closest_points(coord_t p[12]);
    wide_t   a0[3], b0[3], d21[3], d43[3], d13[3];
    wide_t   d1343, d4321, d1321, d4343, d2121, den, na, nb, thr, m;
    bit      b_tiny, a_tiny;
    answer_t r;
    r = '0;
    thr = point_thr;
    b_tiny = 1'b1;
    a_tiny = 1'b1;
    d1343 = 0; d4321 = 0; d1321 = 0; d4343 = 0; d2121 = 0;
    for (int k = 0; k < 3; k++) begin
      a0[k]  = p[k];
      b0[k]  = p[6 + k];
      d21[k] = wide_t'(p[3 + k]) - a0[k];
      d43[k] = wide_t'(p[9 + k]) - b0[k];
      d13[k] = a0[k] - b0[k];
      m = d43[k] < 0 ? -d43[k] : d43[k];
      if (m >= thr) b_tiny = 1'b0;
      m = d21[k] < 0 ? -d21[k] : d21[k];
      if (m >= thr) a_tiny = 1'b0;
      d1343 += d13[k] * d43[k];
      d4321 += d43[k] * d21[k];
      d1321 += d13[k] * d21[k];
      d4343 += d43[k] * d43[k];
      d2121 += d21[k] * d21[k];
    end
    if (b_tiny) begin
      r.status = ST_B_DEGEN;
      return r;
    end
    if (a_tiny) begin
      r.status = ST_A_DEGEN;
      return r;
    end
    den = d2121 * d4343 - d4321 * d4321;
    thr = par_thr;
    if (den == 0 || den < thr) begin
      r.status = ST_PARALLEL;
      return r;
    end
    na = d1343 * d4321 - d1321 * d4343;
    nb = d1343 * d2121 - d4321 * d1321;
    r.status   = ST_FOUND;
    r.near_a_x = saturate(a0[0] + (na * d21[0]) / den);
    r.near_a_y = saturate(a0[1] + (na * d21[1]) / den);
    r.near_a_z = saturate(a0[2] + (na * d21[2]) / den);
    r.near_b_x = saturate(b0[0] + (nb * d43[0]) / den);
    r.near_b_y = saturate(b0[1] + (nb * d43[1]) / den);
    r.near_b_z = saturate(b0[2] + (nb * d43[2]) / den);
    r.param_a  = saturate((na <<< FB) / den);
    r.param_b  = saturate((nb <<< FB) / den);
    return r;
  endfunction

  always @(posedge clk) begin
    answer_t got, want;
    coord_t  gv[8], wv[8];
    if (rst_n && out_strobe) begin
      got = '{status_t'(out_status), out_near_a_x, out_near_a_y, out_near_a_z,
              out_near_b_x, out_near_b_y, out_near_b_z, out_param_a, out_param_b};
      answers_seen++;
      status_hits[out_status]++;
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result beat, status %0d", $realtime, out_status);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        gv = '{got.near_a_x, got.near_a_y, got.near_a_z, got.near_b_x,
               got.near_b_y, got.near_b_z, got.param_a, got.param_b};
        wv = '{want.near_a_x, want.near_a_y, want.near_a_z, want.near_b_x,
               want.near_b_y, want.near_b_z, want.param_a, want.param_b};
        if (got.status != want.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime, want.status, got.status);
          errors++;
        end
        for (int k = 0; k < 8; k++)
          if (gv[k] !== wv[k]) begin
            $display("%0t: output field %0d expected %0d actual %0d",
                     $realtime, k, wv[k], gv[k]);
            errors++;
          end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_cfg(logic [CIW-1:0] idx, logic [PRW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_POINT_THR) point_thr = data[PTW-1:0];
    else if (idx == CFG_PAR_THR) par_thr = data;
    @(posedge clk);
  endtask

  // send one beat; optionally hold off afterward
  task automatic send_query(coord_t p[12], bit known, answer_t ans, bit allow_gap);
    int gap;
    start <= 1'b1;
    for (int k = 0; k < 12; k++) pt[k] <= p[k];
    do @(posedge clk); while (busy);
    expect_answer(known ? ans : closest_points(p));
    queries_sent++;
    if (allow_gap && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'(($urandom_range(0, 4000) - 2000) * 1024);
      2: return coord_t'($urandom_range(0, 200)) - 100;
      default: return ($urandom_range(0, 1) != 0) ? CMAX : CMIN;
    endcase
  endfunction

  task automatic random_query(bit allow_gap);
    coord_t  p[12];
    int      kind, mode;
    int      scale;
    answer_t none;
    none = '0;
    kind = $urandom_range(0, 9);
    mode = ($urandom_range(0, 19) == 0) ? 3 : $urandom_range(0, 1);
    for (int k = 0; k < 12; k++) p[k] = rand_coord(mode);
    case (kind)
      0: for (int k = 0; k < 3; k++) p[9 + k] = p[6 + k] + rand_coord(2) / 8;
      1: for (int k = 0; k < 3; k++) p[3 + k] = p[k] + rand_coord(2) / 8;
      2, 3: begin
        scale = $urandom_range(1, 4);
        for (int k = 0; k < 3; k++) begin
          p[k]     = rand_coord(1);
          p[3 + k] = p[k] + rand_coord(1) / 8;
          p[6 + k] = rand_coord(1);
          p[9 + k] = p[6 + k] + (p[3 + k] - p[k]) * scale + rand_coord(2) / 64;
        end
      end
      default: ;
    endcase
    send_query(p, 1'b0, none, allow_gap);
  endtask

  initial begin
    answer_t    zero_ans;
    int         setting;
    coord_t     a0z[12];
    errors = 0;
    queries_sent = 0;
    answers_seen = 0;
    idle_cycles = 0;
    status_hits = '{0, 0, 0, 0};
    rst_n = 1'b0;
    start = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int k = 0; k < 12; k++) pt[k] = '0;
    point_thr = 16'd1;
    par_thr = 32'd1;
    zero_ans = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    a0z = '{default: '0};
    add_row('{a0z, 1'b1, '{ST_B_DEGEN, 0, 0, 0, 0, 0, 0, 0, 0}});
    add_row('{'{0, 0, 0, ONE, 0, 0, 5, 5, 5, 5, 5, 5}, 1'b1,
              '{ST_B_DEGEN, 0, 0, 0, 0, 0, 0, 0, 0}});
    add_row('{'{7, 7, 7, 7, 7, 7, 0, 0, 0, 0, ONE, 0}, 1'b1,
              '{ST_A_DEGEN, 0, 0, 0, 0, 0, 0, 0, 0}});
    add_row('{'{0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE, ONE, 0}, 1'b1,
              '{ST_PARALLEL, 0, 0, 0, 0, 0, 0, 0, 0}});
    add_row('{'{0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, ONE, ONE}, 1'b1,
              '{ST_FOUND, 0, 0, 0, 0, ONE, 0, 0, 0}});
    add_row('{'{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMIN, CMAX,
                CMIN, CMAX, CMIN}, 1'b0, zero_ans});
    add_row('{'{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMAX, CMIN,
                CMAX, CMIN, CMAX}, 1'b0, zero_ans});
    add_row('{'{CMIN, 0, 0, CMAX, 1, 0, 0, CMIN, CMAX, 1, CMAX, CMIN},
              1'b0, zero_ans});
    add_row('{'{0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 1, 0}, 1'b0, zero_ans});
    add_row('{'{0, 0, 0, 1, 1, 0, 3, 0, 0, 3, 0, 1}, 1'b0, zero_ans});
    add_row('{'{CMAX, 0, 0, CMAX - 1, 0, 0, CMIN, 5, 0, CMIN, 4, 1}, 1'b0, zero_ans});
    add_row('{'{0, 0, 0, 3, 0, 0, CMAX, CMAX, 0, CMIN, CMAX, 2}, 1'b0, zero_ans});
    add_row('{'{1, 2, 3, 100, 200, 300, -5, 9, 2, 50, -80, 7}, 1'b0, zero_ans});
    foreach (rows[i]) send_query(rows[i].pt, rows[i].known, rows[i].ans, 1'b1);
    drain();

    for (setting = 0; setting < 5; setting++) begin
      case (setting)
        0: ;
        1: begin
          write_cfg(CFG_POINT_THR, '0);
          write_cfg(CFG_PAR_THR, '0);
        end
        2: begin
          write_cfg(CFG_POINT_THR, 32'h1234_FFFF);
          write_cfg(CFG_PAR_THR, 32'hFFFF_FFFF);
          write_cfg(CFG_UNUSED, 32'h0000_0007);
        end
        3: begin
          write_cfg(CFG_POINT_THR, 32'($urandom_range(2, 300)));
          write_cfg(CFG_PAR_THR, $urandom);
        end
        default: begin
          write_cfg(CFG_POINT_THR, 32'd1);
          write_cfg(CFG_PAR_THR, 32'd1);
        end
      endcase
      for (int i = 0; i < 400; i++) random_query(setting < 4);
      drain();
    end

    $display("Ran %0d queries through five threshold settings, %0d results checked.",
             queries_sent, answers_seen);
    $display("Status mix: found %0d, line b degenerate %0d, line a degenerate %0d, parallel %0d.",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3]);
    if (errors == 0 && pending_answers.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

### sim.f
hw/rtl/lcp_pkg.sv
hw/rtl/lcp_front.sv
hw/rtl/lcp_queue.sv
hw/rtl/lcp_mul.sv
hw/rtl/lcp_div.sv
hw/rtl/lcp_back.sv
hw/rtl/line_line_closest_points.sv
tb/sv/tb_line_line_closest_points.sv
